// ----- hw/rtl/gap_difference_triangle_checker_core_assert.svh -----
// Assertion macros for the gap difference triangle checker
`ifndef GAP_DIFFERENCE_TRIANGLE_CHECKER_CORE_ASSERT_SVH
`define GAP_DIFFERENCE_TRIANGLE_CHECKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GDTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GDTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GDTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GDTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/gdtc_pkg.sv -----
// Shared constants, types and helpers of the gap difference triangle checker
package gdtc_pkg;

    localparam int MAX_GAP     = 128;
    localparam int MAX_LEN     = 1024;
    localparam int VALUE_WIDTH = 31;

    localparam int CFG_W    = 8;
    localparam int COUNT_W  = 11;
    localparam int GAP_AW   = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;
    localparam int GAP_CW   = $clog2(MAX_GAP + 1);
    localparam int LEVEL_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DRAIN_W  = $clog2(MAX_LEN + 1);

    typedef logic [VALUE_WIDTH-1:0] t_gdtc_value;

    typedef struct packed {
        logic                 valid;
        logic                 done;
        logic [LEVEL_W-1:0]   level;
        t_gdtc_value          val;
    } t_gdtc_wave;

    typedef struct packed {
        logic        item;
        logic        last;
        logic        has_diff;
        t_gdtc_value diff;
    } t_gdtc_front;

    function automatic t_gdtc_value gdtc_absdiff(t_gdtc_value a, t_gdtc_value b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ----- hw/rtl/gdtc_if.sv -----
// Request channel interfaces of the gap difference triangle checker
interface gdtc_in_if import gdtc_pkg::*; ();
    logic        valid;
    logic        ready;
    t_gdtc_value value;
    logic        last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface gdtc_out_if import gdtc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               passed;
    logic [COUNT_W-1:0] fail_level;
    logic [COUNT_W-1:0] diff_count;
    logic               overflow;

    modport source (output valid, output passed, output fail_level, output diff_count,
                    output overflow, input ready);
    modport sink   (input valid, input passed, input fail_level, input diff_count,
                    input overflow, output ready);
endinterface

// ----- hw/rtl/gdtc_gap_line.sv -----
// Gap delay line and gap difference front end
module gdtc_gap_line import gdtc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  t_gdtc_value      i_value,
    input  logic             i_last,
    input  logic [CFG_W-1:0] i_gap,
    output t_gdtc_front      o_front
);

    localparam int SUM_W = GAP_CW + 1;

    t_gdtc_value        r_mem [MAX_GAP];
    t_gdtc_value        r_rd_data;
    logic [GAP_AW-1:0]  r_wr_pos;
    logic [GAP_CW-1:0]  r_in_count;
    logic               r_b_item;
    logic               r_b_last;
    logic               r_b_has;
    t_gdtc_value        r_b_value;
    t_gdtc_front        r_c;

    logic [GAP_CW-1:0]  gap_eff;
    logic [SUM_W-1:0]   rd_sum;
    logic [GAP_AW-1:0]  rd_addr;

    always_comb begin
        if (i_gap == '0) begin
            gap_eff = GAP_CW'(1);
        end else if (32'(i_gap) > 32'(MAX_GAP)) begin
            gap_eff = GAP_CW'(MAX_GAP);
        end else begin
            gap_eff = GAP_CW'(i_gap);
        end
        rd_sum = SUM_W'(r_wr_pos) + SUM_W'(MAX_GAP) - SUM_W'(gap_eff);
        if (32'(rd_sum) >= 32'(MAX_GAP)) begin
            rd_addr = GAP_AW'(rd_sum - SUM_W'(MAX_GAP));
        end else begin
            rd_addr = GAP_AW'(rd_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_mem[r_wr_pos] <= i_value;
            r_rd_data       <= r_mem[rd_addr];
            r_b_value       <= i_value;
            r_b_last        <= i_last;
            r_b_has         <= (r_in_count >= gap_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        r_c.last     <= r_b_last;
        r_c.has_diff <= r_b_has;
        r_c.diff     <= gdtc_absdiff(r_rd_data, r_b_value);
        if (!i_rst_n) begin
            r_wr_pos   <= '0;
            r_in_count <= '0;
            r_b_item   <= 1'b0;
            r_c.item   <= 1'b0;
        end else begin
            r_b_item <= i_take;
            r_c.item <= r_b_item;
            if (i_take) begin
                r_wr_pos <= (32'(r_wr_pos) == MAX_GAP - 1) ? '0 : r_wr_pos + 1'b1;
                if (i_last) begin
                    r_in_count <= '0;
                end else if (32'(r_in_count) < MAX_GAP) begin
                    r_in_count <= r_in_count + 1'b1;
                end
            end
        end
    end

    assign o_front = r_c;

endmodule

// ----- hw/rtl/gdtc_cell.sv -----
// One triangle cell: newest element of one row and the wave register behind it
module gdtc_cell import gdtc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [LEVEL_W-1:0] i_index,
    input  t_gdtc_wave         i_wave,
    output t_gdtc_wave         o_wave
);

    t_gdtc_value r_row;
    t_gdtc_wave  r_out;
    t_gdtc_wave  n_out;
    logic        active;
    logic        terminal;

    always_comb begin
        active   = i_wave.valid && !i_wave.done;
        terminal = active && (i_wave.level == i_index);
        n_out    = i_wave;
        if (terminal) begin
            n_out.done  = 1'b1;
            n_out.valid = (i_index != '0) && (i_wave.val != VALUE_WIDTH'(1));
        end else if (active) begin
            n_out.val = gdtc_absdiff(r_row, i_wave.val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (active) begin
            r_row <= i_wave.val;
        end
        r_out.done  <= n_out.done;
        r_out.level <= n_out.level;
        r_out.val   <= n_out.val;
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= n_out.valid;
        end
    end

    assign o_wave = r_out;

endmodule

// ----- hw/rtl/gap_difference_triangle_checker_core.sv -----
// Top level of the gap difference triangle checker
//
// Input channel i_in carries one number of a sequence per request, with last
// on the final one. Each number is differenced against the one gap requests
// earlier; the differences run down a chain of MAX_LEN cells, one cell per
// triangle row, each wave moving one cell per cycle. Output channel o_out
// carries one request per sequence: passed, fail_level, diff_count, overflow.
// Numbers are taken one per cycle. After the last number is taken, input
// ready stays low until the result is loaded, which waits for the last
// difference to leave the cell chain and for the output register to be free.
// With the chain empty and no difference from the last number, the result is
// loaded once its end flag has passed the gap line's two registers and the
// tail register. The result sits in an output register, so the next sequence
// may start while the result waits for the receiver; a stalled receiver only
// holds off the next sequence's end.
// The gap register resets to 1 and is written through i_cfg_we / i_cfg_wdata;
// the user must write it only while idle, which the block does not enforce.
// Synchronous reset clears control state and sequence counters; the delay line
// and rows keep their contents, never read before written within a sequence.
`include "gap_difference_triangle_checker_core_assert.svh"

module gap_difference_triangle_checker_core import gdtc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    gdtc_in_if.sink          i_in,
    gdtc_out_if.source       o_out
);

    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_DRAIN = 2'b10
    } t_gdtc_state;

    t_gdtc_state        r_state;
    logic [CFG_W-1:0]   r_gap;
    logic [COUNT_W-1:0] r_row_count;
    logic               r_overflow;
    logic               r_failed;
    logic [LEVEL_W-1:0] r_fail_level;
    logic               r_tail;
    logic [DRAIN_W-1:0] r_drain;
    logic               r_out_valid;
    logic               r_passed;
    logic [COUNT_W-1:0] r_out_level;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_overflow;

    logic               take;
    logic               load;
    t_gdtc_front        front;
    t_gdtc_wave         launch;
    t_gdtc_wave         w_in  [MAX_LEN];
    t_gdtc_wave         w_out [MAX_LEN];
    t_gdtc_wave         chain_end;

    assign i_in.ready = (r_state == S_RUN);
    assign take       = i_in.valid && i_in.ready;

    gdtc_gap_line u_gap_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_value (i_in.value),
        .i_last  (i_in.last),
        .i_gap   (r_gap),
        .o_front (front)
    );

    always_comb begin
        launch.valid = front.item && front.has_diff && (r_row_count < COUNT_W'(MAX_LEN));
        launch.done  = 1'b0;
        launch.level = LEVEL_W'(r_row_count);
        launch.val   = front.diff;
    end

    assign w_in[0] = launch;

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        if (j > 0) begin : g_link
            assign w_in[j] = w_out[j-1];
        end
        gdtc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (LEVEL_W'(j)),
            .i_wave  (w_in[j]),
            .o_wave  (w_out[j])
        );
    end

    assign chain_end = w_out[MAX_LEN-1];

    assign load = (r_state == S_DRAIN) && r_tail && (r_drain == '0)
                  && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_gap        <= CFG_W'(1);
            r_row_count  <= '0;
            r_overflow   <= 1'b0;
            r_failed     <= 1'b0;
            r_fail_level <= '0;
            r_tail       <= 1'b0;
            r_drain      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gap <= i_cfg_wdata;
            end

            unique case (r_state)
                S_RUN: begin
                    if (take && i_in.last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (load) begin
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase

            if (launch.valid) begin
                r_drain <= DRAIN_W'(MAX_LEN);
            end else if (r_drain != '0) begin
                r_drain <= r_drain - 1'b1;
            end

            if (front.item && front.last) begin
                r_tail <= 1'b1;
            end else if (load) begin
                r_tail <= 1'b0;
            end

            if (load) begin
                r_row_count <= '0;
                r_overflow  <= 1'b0;
            end else if (front.item && front.has_diff) begin
                if (launch.valid) begin
                    r_row_count <= r_row_count + 1'b1;
                end else begin
                    r_overflow <= 1'b1;
                end
            end

            if (load) begin
                r_failed     <= 1'b0;
                r_fail_level <= '0;
            end else if (chain_end.valid && !r_failed) begin
                r_failed     <= 1'b1;
                r_fail_level <= chain_end.level;
            end

            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_passed       <= !r_failed;
            r_out_level    <= r_failed ? COUNT_W'(r_fail_level) : '0;
            r_out_count    <= r_row_count;
            r_out_overflow <= r_overflow;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.passed     = r_passed;
    assign o_out.fail_level = r_out_level;
    assign o_out.diff_count = r_out_count;
    assign o_out.overflow   = r_out_overflow;

    `GDTC_ASSERT_IMP(a_tail_in_drain, i_clk, i_rst_n, r_tail, r_state == S_DRAIN, "sequence end seen outside drain")
    `GDTC_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_row_count <= COUNT_W'(MAX_LEN), "row count beyond triangle size")
    `GDTC_ASSERT_IMP(a_overflow_full, i_clk, i_rst_n, r_overflow, r_row_count == COUNT_W'(MAX_LEN), "overflow with room left")
    `GDTC_ASSERT_IMP(a_fail_row, i_clk, i_rst_n, r_failed, r_fail_level != '0, "row zero reported as failing")
    `GDTC_ASSERT_NXT(a_load_restart, i_clk, i_rst_n, load, r_out_valid && (r_state == S_RUN) && (r_row_count == '0), "result load did not restart the sequence")

endmodule
